// ===== rtl/core/idq_pkg.sv =====
// Shared types, widths and codes for the indexed deque with removal.
package idq_pkg;

    localparam int KEY_SPACE = 4096;
    localparam int KEY_W     = 12;
    localparam int CNT_W     = 13;
    localparam int KEY_AW    = $clog2(KEY_SPACE);

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [KEY_AW-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [2:0] {
        REQ_PUSH     = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_POP_HEAD = 3'd2,
        REQ_POP_TAIL = 3'd3,
        REQ_TEST     = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic cap;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_stat;

    function automatic t_addr key_addr(input t_key k);
        return KEY_AW'(k);
    endfunction

endpackage

// ===== rtl/core/idq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module idq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/idq_dp.sv =====
// Datapath: link and membership memories, head, tail, count and result registers.
module idq_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idq_pkg::t_cmd        i_cmd,
    output idq_pkg::t_stat       o_stat,
    input  logic [2:0]           i_req_type,
    input  idq_pkg::t_key        i_key,
    output logic [1:0]           o_status,
    output idq_pkg::t_key        o_out_key,
    output idq_pkg::t_count      o_entry_count
);

    logic [2:0]       r_req;
    idq_pkg::t_key    r_key;
    idq_pkg::t_key    r_node;
    idq_pkg::t_key    r_head, n_head;
    idq_pkg::t_key    r_tail, n_tail;
    idq_pkg::t_count  r_count, n_count;
    idq_pkg::t_addr   r_clr_cnt;
    logic [1:0]       r_status, n_status;
    idq_pkg::t_key    r_okey, n_okey;

    idq_pkg::t_key    rd_node;
    idq_pkg::t_key    nxt_q, prv_q;
    logic             pres_q;
    idq_pkg::t_key    node_n, node_p;
    logic             in_space, cnt_gt1;

    logic             nxt_we, prv_we, pres_we;
    idq_pkg::t_addr   nxt_wa, prv_wa, pres_wa;
    idq_pkg::t_key    nxt_wd, prv_wd;
    logic             pres_wd, pres_bit;

    // Node whose links are read: head or tail for pops, the request key otherwise.
    always_comb begin
        case (i_req_type)
            idq_pkg::REQ_POP_HEAD: rd_node = r_head;
            idq_pkg::REQ_POP_TAIL: rd_node = r_tail;
            default:               rd_node = i_key;
        endcase
    end

    idq_ram #(.WIDTH(idq_pkg::KEY_W), .DEPTH(idq_pkg::KEY_SPACE)) u_next (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_wa),
        .i_wdata (nxt_wd),
        .i_re    (i_cmd.cap),
        .i_raddr (idq_pkg::key_addr(rd_node)),
        .o_rdata (nxt_q)
    );

    idq_ram #(.WIDTH(idq_pkg::KEY_W), .DEPTH(idq_pkg::KEY_SPACE)) u_prev (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_wa),
        .i_wdata (prv_wd),
        .i_re    (i_cmd.cap),
        .i_raddr (idq_pkg::key_addr(rd_node)),
        .o_rdata (prv_q)
    );

    idq_ram #(.WIDTH(1), .DEPTH(idq_pkg::KEY_SPACE)) u_present (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (pres_wa),
        .i_wdata (pres_bit),
        .i_re    (i_cmd.cap),
        .i_raddr (idq_pkg::key_addr(rd_node)),
        .o_rdata (pres_q)
    );

    // The tail's next link and the head's previous link close the circle and
    // are taken from the head and tail registers rather than from memory.
    assign node_n   = (r_node == r_tail) ? r_head : nxt_q;
    assign node_p   = (r_node == r_head) ? r_tail : prv_q;
    assign in_space = 32'(r_key) < idq_pkg::KEY_SPACE;
    assign cnt_gt1  = r_count > idq_pkg::CNT_W'(1);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = idq_pkg::ST_OK;
        n_okey   = '0;
        nxt_we   = 1'b0;
        prv_we   = 1'b0;
        pres_we  = 1'b0;
        nxt_wa   = idq_pkg::key_addr(node_p);
        nxt_wd   = node_n;
        prv_wa   = idq_pkg::key_addr(node_n);
        prv_wd   = node_p;
        pres_wa  = idq_pkg::key_addr(r_node);
        pres_wd  = 1'b0;
        case (r_req)
            idq_pkg::REQ_PUSH: begin
                if (!in_space) begin
                    n_status = idq_pkg::ST_NOTFOUND;
                end else if (pres_q) begin
                    n_status = idq_pkg::ST_DUP;
                end else begin
                    pres_we = 1'b1;
                    pres_wd = 1'b1;
                    n_count = r_count + idq_pkg::CNT_W'(1);
                    n_tail  = r_key;
                    if (r_count == '0) begin
                        n_head = r_key;
                    end else begin
                        nxt_we = 1'b1;
                        nxt_wa = idq_pkg::key_addr(r_tail);
                        nxt_wd = r_key;
                        prv_we = 1'b1;
                        prv_wa = idq_pkg::key_addr(r_key);
                        prv_wd = r_tail;
                    end
                end
            end
            idq_pkg::REQ_REMOVE, idq_pkg::REQ_POP_HEAD, idq_pkg::REQ_POP_TAIL: begin
                if (r_req == idq_pkg::REQ_REMOVE && (!in_space || !pres_q)) begin
                    n_status = idq_pkg::ST_NOTFOUND;
                end else if (r_req != idq_pkg::REQ_REMOVE && r_count == '0) begin
                    n_status = idq_pkg::ST_EMPTY;
                end else begin
                    if (r_req != idq_pkg::REQ_REMOVE) begin
                        n_okey = r_node;
                    end
                    pres_we = 1'b1;
                    n_count = r_count - idq_pkg::CNT_W'(1);
                    if (cnt_gt1) begin
                        nxt_we = 1'b1;
                        prv_we = 1'b1;
                        if (r_node == r_head) begin
                            n_head = node_n;
                        end
                        if (r_node == r_tail) begin
                            n_tail = node_p;
                        end
                    end
                end
            end
            idq_pkg::REQ_TEST: begin
                if (!in_space || !pres_q) begin
                    n_status = idq_pkg::ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
        if (!i_cmd.exec) begin
            nxt_we  = 1'b0;
            prv_we  = 1'b0;
            pres_we = 1'b0;
        end
        // The clearing pass owns the membership memory after reset.
        if (i_cmd.clr) begin
            pres_we = 1'b1;
            pres_wa = r_clr_cnt;
            pres_wd = 1'b0;
        end
    end

    assign pres_bit = pres_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + idq_pkg::KEY_AW'(1);
            end
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req  <= i_req_type;
            r_key  <= i_key;
            r_node <= rd_node;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_okey   <= n_okey;
        end
    end

    assign o_stat.clr_last = (r_clr_cnt == idq_pkg::KEY_AW'(idq_pkg::KEY_SPACE - 1));
    assign o_status        = r_status;
    assign o_out_key       = r_okey;
    assign o_entry_count   = r_count;

endmodule

// ===== rtl/core/idq_ctrl.sv =====
// Controller: clearing pass, request sequencing and result-valid register.
module idq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  idq_pkg::t_stat i_stat,
    output idq_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLR  = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_cmd.clr  = (r_state == S_CLR);
    assign o_cmd.cap  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:   if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_cap_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result was dropped");

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!r_out_valid && o_in_stall))
        else $error("activity during the clearing pass");

    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_IDLE && r_out_valid))
        else $error("commit did not deliver a result");

endmodule

// ===== rtl/core/indexed_deque_with_removal_top.sv =====
// Top level of the indexed deque with removal: controller and datapath.
//
//  Channel   Direction  Handshake                 Payload
//  request   in         i_in_valid / o_in_stall   i_req_type[2:0], i_key[11:0]
//  result    out        o_out_valid / i_out_stall o_status[1:0], o_out_key[11:0],
//                                                 o_entry_count[12:0]
//
// Each request first reads the node's links and membership bit from the
// key-indexed memories, then writes both neighbours and commits.
// After reset a clearing pass zeroes all 4096 entries of the membership
// memory; the request channel is stalled throughout it.
// A new request is taken while the previous result still waits in the output
// register; a request only commits once that register is free.
module indexed_deque_with_removal_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [11:0] i_key,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_out_key,
    output logic [12:0] o_entry_count
);

    idq_pkg::t_cmd  cmd;
    idq_pkg::t_stat stat;

    // The controller sequences each transfer: capture, then commit.
    idq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the list itself and the result registers.
    idq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_entry_count (o_entry_count)
    );

endmodule

// ===== verif/tb_indexed_deque_with_removal_top.sv =====
// Self-checking testbench for the indexed deque with removal.
`timescale 1ns / 1ps

module tb_indexed_deque_with_removal_top;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 1025;
    localparam int POOL_SIZE      = 32;
    localparam int MAX_WAIT       = 15;
    localparam int HOLDOFF_AT     = 400;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    // The clearing pass over all 4096 membership entries after reset is quiet,
    // and the long hold-off of the receiver adds a quiet stretch of its own.
    localparam int QUIET_LIMIT    = 20000;

    // Request codes that the block leaves unused.
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [2:0]    req;
        idq_pkg::t_key key;
    } t_dq_request;

    typedef struct packed {
        idq_pkg::t_status status;
        idq_pkg::t_key    out_key;
        idq_pkg::t_count  entry_count;
    } t_dq_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          o_in_stall;
    logic [2:0]    in_req = '0;
    idq_pkg::t_key in_key = '0;
    logic          o_out_valid;
    logic          out_stall = 1'b0;
    logic [1:0]    o_status;
    logic [11:0]   o_out_key;
    logic [12:0]   o_entry_count;

    indexed_deque_with_removal_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (in_req),
        .i_key         (in_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_entry_count (o_entry_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Requests waiting to be offered, and results predicted but not yet seen.
    t_dq_request pending_reqs [$];
    t_dq_result  awaited_results [$];

    // Transfer flags, captured at each rising edge and used by the driving
    // processes at the following falling edge.
    logic in_taken  = 1'b0;
    logic res_taken = 1'b0;
    int   reqs_taken = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor: our own copy of the linked list. The link tables need no
    // reset since an entry is only ever read for a key that is held.
    // ------------------------------------------------------------------
    idq_pkg::t_key   succ_of [idq_pkg::KEY_SPACE];
    idq_pkg::t_key   pred_of [idq_pkg::KEY_SPACE];
    bit              held [idq_pkg::KEY_SPACE];
    idq_pkg::t_key   front_key = '0;
    idq_pkg::t_key   back_key = '0;
    idq_pkg::t_count live_count = '0;

    // Unlinks a held key. The caller guarantees that the list is not empty.
    // When the last key leaves, head and tail keep their stale values.
    function automatic void drop_key(input idq_pkg::t_key k);
        idq_pkg::t_key nk;
        idq_pkg::t_key pk;
        nk = succ_of[k];
        pk = pred_of[k];
        if (live_count > 1) begin
            pred_of[nk] = pk;
            succ_of[pk] = nk;
            if (k == front_key) front_key = nk;
            if (k == back_key) back_key = pk;
        end
        held[k] = 1'b0;
        live_count = live_count - 1'b1;
    endfunction

    // Applies one request to the predicted list and returns its result.
    // Every 12-bit key lies inside the key space, so the out-of-range
    // rejection can never arise here.
    function automatic t_dq_result apply_request(input logic [2:0] req,
                                                 input idq_pkg::t_key k);
        t_dq_result    r;
        idq_pkg::t_key victim;
        r.status  = idq_pkg::ST_OK;
        r.out_key = '0;
        case (req)
            idq_pkg::REQ_PUSH: begin
                if (held[k]) begin
                    r.status = idq_pkg::ST_DUP;
                end else begin
                    if (live_count == 0) begin
                        succ_of[k] = k;
                        pred_of[k] = k;
                        front_key  = k;
                    end else begin
                        succ_of[k]        = front_key;
                        pred_of[k]        = back_key;
                        succ_of[back_key] = k;
                        pred_of[front_key] = k;
                    end
                    back_key   = k;
                    held[k]    = 1'b1;
                    live_count = live_count + 1'b1;
                end
            end
            idq_pkg::REQ_REMOVE: begin
                if (!held[k]) r.status = idq_pkg::ST_NOTFOUND;
                else drop_key(k);
            end
            idq_pkg::REQ_POP_HEAD, idq_pkg::REQ_POP_TAIL: begin
                if (live_count == 0) begin
                    r.status = idq_pkg::ST_EMPTY;
                end else begin
                    victim    = (req == idq_pkg::REQ_POP_HEAD) ? front_key : back_key;
                    r.out_key = victim;
                    drop_key(victim);
                end
            end
            idq_pkg::REQ_TEST: begin
                if (!held[k]) r.status = idq_pkg::ST_NOTFOUND;
            end
            default: ;
        endcase
        r.entry_count = live_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver of the request channel. After each transfer it draws a random
    // gap; in calm stretches there is no gap, so requests follow back to
    // back. Valid is assigned once per falling edge, so a request that
    // directly follows another keeps valid high throughout.
    // ------------------------------------------------------------------
    int in_gap = 0;
    bit in_calm = 1'b0;

    always @(negedge i_clk) begin
        logic        next_valid;
        t_dq_request item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && in_taken) begin
                next_valid = 1'b0;
                if ($urandom_range(0, 29) == 0) in_calm = ~in_calm;
                in_gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    item = pending_reqs.pop_front();
                    in_req <= item.req;
                    in_key <= item.key;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Receiver of the result channel. After each transfer it stalls for a
    // drawn number of cycles. Once, after a few hundred requests, it also
    // holds off for a long stretch while the sender keeps offering, which
    // fills the block up and forces it to stall its request channel.
    // ------------------------------------------------------------------
    int res_wait = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    bit out_calm = 1'b0;

    always @(negedge i_clk) begin
        if (!holdoff_done && reqs_taken >= HOLDOFF_AT) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
        end
        if (res_taken) begin
            if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
            res_wait = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end else if (res_wait > 0) begin
            res_wait = res_wait - 1;
        end
        out_stall <= (holdoff_left > 0) || (res_wait > 0);
    end

    // ------------------------------------------------------------------
    // Monitor. At each rising edge it checks a result transfer against the
    // oldest prediction first, and only then predicts the result of a
    // request transfer in the same edge, so the two can never be confused.
    // A watchdog ends the run when nothing has moved for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dq_result want;
        logic       req_xfer;
        logic       res_xfer;
        req_xfer = i_rst_n && in_valid && !o_in_stall;
        res_xfer = i_rst_n && o_out_valid && !out_stall;
        in_taken  <= req_xfer;
        res_taken <= res_xfer;
        if (res_xfer) begin
            if (awaited_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d key %0d count %0d",
                             o_status, o_out_key, o_entry_count);
            end else begin
                want = awaited_results.pop_front();
                if (o_status != want.status || o_out_key != want.out_key ||
                    o_entry_count != want.entry_count) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected status %0d key %0d count %0d,",
                                  " got status %0d key %0d count %0d"},
                                 want.status, want.out_key, want.entry_count,
                                 o_status, o_out_key, o_entry_count);
                end
            end
        end
        if (req_xfer) begin
            awaited_results.insert(awaited_results.size(), apply_request(in_req, in_key));
            reqs_taken <= reqs_taken + 1;
        end
        if (i_rst_n) begin
            if (req_xfer || res_xfer) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic add_req(input logic [2:0] r, input idq_pkg::t_key k);
        t_dq_request item;
        item.req = r;
        item.key = k;
        pending_reqs.insert(pending_reqs.size(), item);
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial begin
        idq_pkg::t_key pool [POOL_SIZE];
        idq_pkg::t_key recent [$];
        idq_pkg::t_key k;
        idq_pkg::t_key hit;
        logic [2:0]    r;
        int            roll;

        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = idq_pkg::t_key'($urandom_range(0, idq_pkg::KEY_SPACE - 1));
        pool[0] = '0;
        pool[1] = '1;

        // Directed part: pops and lookups on an empty list, the extreme keys,
        // a duplicate push, removal from the middle, head and tail, removal
        // of the last key held, and the unused request codes.
        add_req(idq_pkg::REQ_POP_HEAD, '1);
        add_req(idq_pkg::REQ_POP_TAIL, '0);
        add_req(idq_pkg::REQ_REMOVE, '0);
        add_req(idq_pkg::REQ_TEST, '1);
        add_req(idq_pkg::REQ_PUSH, '0);
        add_req(idq_pkg::REQ_PUSH, '1);
        add_req(idq_pkg::REQ_PUSH, '0);
        add_req(idq_pkg::REQ_TEST, '0);
        add_req(idq_pkg::REQ_TEST, '1);
        add_req(idq_pkg::REQ_PUSH, 12'hAAA);
        add_req(idq_pkg::REQ_PUSH, 12'h555);
        add_req(idq_pkg::REQ_REMOVE, '1);
        add_req(idq_pkg::REQ_POP_TAIL, '1);
        add_req(idq_pkg::REQ_POP_HEAD, '0);
        add_req(idq_pkg::REQ_REMOVE, 12'hAAA);
        add_req(idq_pkg::REQ_POP_TAIL, 12'h555);
        add_req(idq_pkg::REQ_PUSH, 12'd7);
        add_req(idq_pkg::REQ_REMOVE, 12'd7);
        add_req(idq_pkg::REQ_PUSH, 12'd1);
        add_req(idq_pkg::REQ_PUSH, 12'd2);
        add_req(idq_pkg::REQ_REMOVE, 12'd1);
        add_req(idq_pkg::REQ_PUSH, 12'd3);
        add_req(idq_pkg::REQ_REMOVE, 12'd3);
        add_req(REQ_UNUSED_FIRST, 12'd2);
        add_req(REQ_UNUSED_LAST, '1);

        // Random part in four stretches: a mix over a small pool of keys so
        // that hits and duplicates are common, a growing stretch that builds
        // a long list from keys across the whole range, a shrinking stretch
        // that takes that list apart in random order, and a final mix.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            k    = ($urandom_range(0, 3) == 0) ? idq_pkg::t_key'($urandom)
                                               : pool[$urandom_range(0, POOL_SIZE - 1)];
            hit  = (recent.size() != 0) ? recent[$urandom_range(0, recent.size() - 1)] : k;
            if (n < 300 || n >= 800) begin
                if (roll < 35)      r = idq_pkg::REQ_PUSH;
                else if (roll < 55) r = idq_pkg::REQ_REMOVE;
                else if (roll < 67) r = idq_pkg::REQ_POP_HEAD;
                else if (roll < 79) r = idq_pkg::REQ_POP_TAIL;
                else if (roll < 94) r = idq_pkg::REQ_TEST;
                else                r = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            end else if (n < 550) begin
                if (roll < 70) begin
                    r = idq_pkg::REQ_PUSH;
                    k = idq_pkg::t_key'($urandom);
                    recent.insert(recent.size(), k);
                end else begin
                    r = (roll < 85) ? idq_pkg::REQ_TEST : idq_pkg::REQ_REMOVE;
                    k = hit;
                end
            end else begin
                if (roll < 40) begin
                    r = idq_pkg::REQ_REMOVE;
                    k = hit;
                end else if (roll < 65) begin
                    r = idq_pkg::REQ_POP_HEAD;
                end else if (roll < 90) begin
                    r = idq_pkg::REQ_POP_TAIL;
                end else begin
                    r = idq_pkg::REQ_TEST;
                    k = hit;
                end
            end
            add_req(r, k);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been transferred and every predicted
        // result has come back, then let a few more cycles pass so that any
        // spurious result is still caught.
        while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== indexed_deque_with_removal_top.f =====
rtl/core/idq_pkg.sv
rtl/core/idq_ram.sv
rtl/core/idq_dp.sv
rtl/core/idq_ctrl.sv
rtl/core/indexed_deque_with_removal_top.sv
verif/tb_indexed_deque_with_removal_top.sv
